// ===== hdl/ple_pkg.sv =====
`default_nettype none

package ple_pkg;

  typedef enum logic [2:0] {
    OP_INS_END   = 3'd0,
    OP_INS_FRONT = 3'd1,
    OP_INS_POS   = 3'd2,
    OP_UPDATE    = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_END   = 3'd5,
    OP_DEL_POS   = 3'd6,
    OP_DUMP      = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CM_HOLD   = 3'd0,
    CM_INSERT = 3'd1,
    CM_DELETE = 3'd2,
    CM_UPDATE = 3'd3,
    CM_ROTATE = 3'd4
  } cell_mode_t;

  localparam int unsigned OUT_VALUE_W = 32;
  localparam int unsigned POS_W       = 7;

endpackage

`default_nettype wire

// ===== hdl/ple_cell.sv =====
`default_nettype none

module ple_cell #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned IW         = 6,
  parameter int unsigned IDX        = 0
) (
  input  wire logic                      clk,
  input  wire ple_pkg::cell_mode_t       mode,
  input  wire logic [IW-1:0]             sel_idx,
  input  wire logic [VALUE_BITS-1:0]     prev_d,
  input  wire logic [VALUE_BITS-1:0]     next_d,
  input  wire logic [VALUE_BITS-1:0]     head_d,
  input  wire logic [VALUE_BITS-1:0]     new_d,
  output logic      [VALUE_BITS-1:0]     data_r
);
  import ple_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [VALUE_BITS-1:0] data_nxt;
  logic                  at_sel;
  logic                  above_sel;

  assign at_sel    = (MY_IDX == sel_idx);
  assign above_sel = (MY_IDX > sel_idx);

  always_comb begin
    data_nxt = data_r;
    unique case (mode)
      CM_INSERT: begin
        if (above_sel) data_nxt = prev_d;
        else if (at_sel) data_nxt = new_d;
      end
      CM_DELETE: begin
        if (above_sel || at_sel) data_nxt = next_d;
      end
      CM_UPDATE: begin
        if (at_sel) data_nxt = new_d;
      end
      CM_ROTATE: begin
        if (at_sel) data_nxt = head_d;
        else if (!above_sel) data_nxt = next_d;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/positional_list_engine_core.sv =====
`default_nettype none

// Channel | Direction | Beat payload                                  | Handshake
// in_     | in        | opcode, position, value                       | in_valid / in_stall
// out_    | out       | status, entry_value, entry_position, last     | out_valid / out_stall
//
// For insert, delete and update beats the cell chain shifts or loads in the cycle
// the beat is accepted, so one such beat is taken per cycle unless the output is full
// and stalled. A dump of N entries rotates the first N cells once, one entry per
// cycle unless stalled, and the list is back in order when the last entry leaves.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
// A stalled output holds its beat; input is stalled while a dump runs or the
// output register is full and stalled.

module positional_list_engine_core #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [2:0]                        in_opcode,
  input  wire logic [ple_pkg::POS_W-1:0]         in_position,
  input  wire logic signed [ple_pkg::OUT_VALUE_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             out_status,
  output logic signed [ple_pkg::OUT_VALUE_W-1:0] out_entry_value,
  output logic [ple_pkg::POS_W-1:0]              out_entry_position,
  output logic                                   out_last
);
  import ple_pkg::*;

  localparam int unsigned IW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DUMP = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [CW-1:0]           dump_idx_r, dump_idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [OUT_VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic [POS_W-1:0]        out_pos_r, out_pos_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    slot_free;
  logic                    in_accept;
  opcode_t                 op;
  logic [CMP_W-1:0]        pos_e;
  logic [CMP_W-1:0]        cnt_e;
  logic [IW-1:0]           pos_idx;
  logic [IW-1:0]           last_idx;
  logic                    is_full;
  logic                    is_empty;
  logic                    pos_zero;
  logic [CW-1:0]           dump_inc;
  logic                    dump_done;

  cell_mode_t              mode;
  logic [IW-1:0]           sel_idx;
  logic [VALUE_BITS-1:0]   new_word;
  logic [VALUE_BITS-1:0]   cell_data [CAPACITY];

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && slot_free);
  assign in_accept = in_valid && !in_stall;

  assign op       = opcode_t'(in_opcode);
  assign pos_e    = CMP_W'(in_position);
  assign cnt_e    = CMP_W'(count_r);
  assign pos_zero = (in_position == '0);
  assign pos_idx  = IW'(pos_e - CMP_W'(1));
  assign last_idx = IW'(count_r - CW'(1));
  assign is_full  = (count_r == CAP_CNT);
  assign is_empty = (count_r == '0);
  assign new_word = VALUE_BITS'($unsigned(in_value));

  assign dump_inc  = dump_idx_r + CW'(1);
  assign dump_done = (dump_inc == count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    dump_idx_nxt   = dump_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    mode           = CM_HOLD;
    sel_idx        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_valid_nxt  = (op != OP_DUMP);
          out_status_nxt = ST_OK;
          out_value_nxt  = '0;
          out_pos_nxt    = '0;
          out_last_nxt   = 1'b1;
          unique case (op)
            OP_INS_END: begin
              if (is_full) out_status_nxt = ST_FULL;
              else begin
                mode      = CM_INSERT;
                sel_idx   = IW'(count_r);
                count_nxt = count_r + CW'(1);
              end
            end
            OP_INS_FRONT: begin
              if (is_full) out_status_nxt = ST_FULL;
              else begin
                mode      = CM_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_INS_POS: begin
              priority if (pos_zero || pos_e > cnt_e + CMP_W'(1)) out_status_nxt = ST_BADPOS;
              else if (is_full) out_status_nxt = ST_FULL;
              else begin
                mode      = CM_INSERT;
                sel_idx   = pos_idx;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_UPDATE: begin
              priority if (is_empty) out_status_nxt = ST_EMPTY;
              else if (pos_zero || pos_e > cnt_e) out_status_nxt = ST_BADPOS;
              else begin
                mode    = CM_UPDATE;
                sel_idx = pos_idx;
              end
            end
            OP_DEL_FRONT: begin
              if (is_empty) out_status_nxt = ST_EMPTY;
              else begin
                mode      = CM_DELETE;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_DEL_END: begin
              if (is_empty) out_status_nxt = ST_EMPTY;
              else begin
                mode      = CM_DELETE;
                sel_idx   = last_idx;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_DEL_POS: begin
              priority if (is_empty) out_status_nxt = ST_EMPTY;
              else if (pos_zero || pos_e > cnt_e) out_status_nxt = ST_BADPOS;
              else begin
                mode      = CM_DELETE;
                sel_idx   = pos_idx;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_DUMP: begin
              dump_idx_nxt = '0;
              if (!is_empty) state_nxt = S_DUMP;
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (slot_free) begin
          mode           = CM_ROTATE;
          sel_idx        = last_idx;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = OUT_VALUE_W'(cell_data[0]);
          out_pos_nxt    = POS_W'(dump_inc);
          out_last_nxt   = dump_done;
          dump_idx_nxt   = dump_inc;
          if (dump_done) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] prev_d;
    logic [VALUE_BITS-1:0] next_d;
    if (g == 0) begin : g_first
      assign prev_d = cell_data[g];
    end else begin : g_inner_prev
      assign prev_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_d = cell_data[g];
    end else begin : g_inner_next
      assign next_d = cell_data[g+1];
    end
    ple_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IW         (IW),
      .IDX        (g)
    ) u_cell (
      .clk     (clk),
      .mode    (mode),
      .sel_idx (sel_idx),
      .prev_d  (prev_d),
      .next_d  (next_d),
      .head_d  (cell_data[0]),
      .new_d   (new_word),
      .data_r  (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_entry_value    = $signed(out_value_r);
  assign out_entry_position = out_pos_r;
  assign out_last           = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_dump_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (dump_idx_r < count_r))
    else $error("dump index past entry count");

  a_count_only_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(in_accept)) |-> $stable(count_r))
    else $error("entry count changed without an input beat");

  a_dump_exit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DUMP) && slot_free && dump_done) |=> (state_r == S_IDLE) && out_last_r)
    else $error("dump did not end on its last entry");

endmodule

`default_nettype wire
